/* src/obstacle_speed_governor_top_macros.svh */
// ----------------------------------------------------------------------------
// Obstacle speed governor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_SPEED_GOVERNOR_TOP_MACROS_SVH
`define OBSTACLE_SPEED_GOVERNOR_TOP_MACROS_SVH

// same-cycle implication
`define OSG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("obstacle speed governor: same-cycle check failed");

// next-cycle implication
`define OSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("obstacle speed governor: next-cycle check failed");

`endif

/* src/osg_pkg.sv */
// ----------------------------------------------------------------------------
// Obstacle speed governor package
// Types, register indexes and constants shared by controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package osg_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'b1;

  localparam logic [15:0] SAFE_TIME_RESET = 16'd5000;
  localparam logic [15:0] RADIUS_RESET    = 16'd200;
  localparam logic [14:0] LIMIT_MAX       = 15'd32767;
  localparam logic [15:0] MS_PER_S        = 16'd1000;

  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_CMD  = 1'b1;

  // divider: 30-bit dividend, 16-bit divisor, two quotient bits a cycle
  localparam int unsigned DIV_NUM_W = 30;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DIV_ITERS = DIV_NUM_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_DSTART = 5'b00100,
    S_DWAIT  = 5'b01000,
    S_DONE   = 5'b10000
  } osg_state_t;

  typedef struct packed {
    logic accept;
    logic mul_go;
    logic div_start;
    logic finish;
  } osg_cmd_t;

  typedef struct packed {
    logic kind_cmd_now;
    logic last_now;
    logic exceed_now;
    logic kind_cmd;
    logic div_done;
    logic out_free;
  } osg_sts_t;

endpackage

`default_nettype wire

/* src/osg_div.sv */
// ----------------------------------------------------------------------------
// Obstacle speed governor divider
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module osg_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [osg_pkg::DIV_NUM_W-1:0]         num,
  input  wire logic [osg_pkg::DIV_DEN_W-1:0]         den,
  output logic                                       done,
  output logic [osg_pkg::DIV_NUM_W-1:0]              quo
);

  logic [osg_pkg::DIV_NUM_W-1:0] nq;
  logic [osg_pkg::DIV_DEN_W-1:0] rem;
  logic [osg_pkg::DIV_DEN_W-1:0] den_q;
  logic [osg_pkg::DIV_CNT_W-1:0] count;
  logic                          busy;
  logic [osg_pkg::DIV_NUM_W-1:0] nq_next;
  logic [osg_pkg::DIV_DEN_W-1:0] rem_next;

  always_comb begin
    logic [osg_pkg::DIV_DEN_W:0]   r;
    logic [osg_pkg::DIV_NUM_W-1:0] n;
    logic [osg_pkg::DIV_DEN_W-1:0] rr;
    rr = rem;
    n  = nq;
    for (int i = 0; i < osg_pkg::DIV_STEPS; i++) begin
      r = {rr, n[osg_pkg::DIV_NUM_W-1]};
      n = {n[osg_pkg::DIV_NUM_W-2:0], 1'b0};
      if (r >= {1'b0, den_q}) begin
        r    = r - {1'b0, den_q};
        n[0] = 1'b1;
      end
      rr = r[osg_pkg::DIV_DEN_W-1:0];
    end
    nq_next  = n;
    rem_next = rr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= osg_pkg::DIV_CNT_W'(osg_pkg::DIV_ITERS);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == osg_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq    <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      nq  <= nq_next;
      rem <= rem_next;
    end
  end

  assign done = !busy;
  assign quo  = nq;

endmodule

`default_nettype wire

/* src/osg_ctrl.sv */
// ----------------------------------------------------------------------------
// Obstacle speed governor controller
// Sequences accept, multiply, divide and finish for one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "obstacle_speed_governor_top_macros.svh"

module osg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire osg_pkg::osg_sts_t sts,
  output osg_pkg::osg_cmd_t      cmd
);

  osg_pkg::osg_state_t state, state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      osg_pkg::S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          if (sts.kind_cmd_now) begin
            state_next = sts.exceed_now ? osg_pkg::S_MUL : osg_pkg::S_DONE;
          end else if (sts.last_now) begin
            state_next = osg_pkg::S_MUL;
          end
        end
      end
      osg_pkg::S_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = osg_pkg::S_DSTART;
      end
      osg_pkg::S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = osg_pkg::S_DWAIT;
      end
      osg_pkg::S_DWAIT: begin
        if (sts.div_done) begin
          state_next = osg_pkg::S_DONE;
        end
      end
      osg_pkg::S_DONE: begin
        // hold a command result until the output register is free
        if (!sts.kind_cmd || sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = osg_pkg::S_IDLE;
        end
      end
      default: state_next = osg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= osg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != osg_pkg::S_IDLE);

  `OSG_ASSERT_NEXT(a_div_runs, state == osg_pkg::S_DSTART, !sts.div_done)
  `OSG_ASSERT_IMPL(a_finish_free, cmd.finish && sts.kind_cmd, sts.out_free)

endmodule

`default_nettype wire

/* src/osg_dpath.sv */
// ----------------------------------------------------------------------------
// Obstacle speed governor datapath
// Clearance tracking, limit register, shared multiplier and divider, output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "obstacle_speed_governor_top_macros.svh"

module osg_dpath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [osg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                      cfg_data,
  input  wire logic                             req_type,
  input  wire logic [15:0]                      range_mm,
  input  wire logic                             last_sample,
  input  wire logic signed [15:0]               linear_in,
  input  wire logic signed [15:0]               angular_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [15:0]                    linear_out,
  output logic signed [15:0]                    angular_out,
  output logic                                  was_limited,
  input  wire osg_pkg::osg_cmd_t                cmd,
  output osg_pkg::osg_sts_t                     sts
);

  logic [15:0]        safe_time_ms;
  logic [15:0]        robot_radius_mm;
  logic signed [16:0] least_clearance;
  logic               scan_started;
  logic [14:0]        speed_limit;

  logic               kind_q;
  logic               exceed_q;
  logic signed [15:0] lin_q;
  logic signed [15:0] ang_q;
  logic [osg_pkg::DIV_NUM_W-1:0] prod_q;

  logic signed [16:0] clear_now;
  logic [15:0]        mag_now;
  logic [15:0]        lin_mag;
  logic [15:0]        ang_mag;
  logic [15:0]        clr;
  logic [15:0]        op_a;
  logic [15:0]        op_b;
  logic [31:0]        prod;
  logic [15:0]        div_den;
  logic [15:0]        t_eff;
  logic               div_done;
  logic [osg_pkg::DIV_NUM_W-1:0] quo;
  logic [14:0]        lim_sat;
  logic [15:0]        q16;
  logic               scan_acc;
  logic               load_out;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      safe_time_ms    <= osg_pkg::SAFE_TIME_RESET;
      robot_radius_mm <= osg_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        osg_pkg::REG_SAFE_TIME: safe_time_ms    <= cfg_data;
        osg_pkg::REG_RADIUS:    robot_radius_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  assign clear_now = $signed({1'b0, range_mm}) - $signed({1'b0, robot_radius_mm});
  assign mag_now   = linear_in[15] ? 16'(-linear_in) : linear_in;
  assign scan_acc  = cmd.accept && (req_type == osg_pkg::REQ_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      least_clearance <= '0;
      scan_started    <= 1'b0;
    end else if (scan_acc) begin
      if (!scan_started || (clear_now < least_clearance)) begin
        least_clearance <= clear_now;
      end
      scan_started <= !last_sample;
    end
  end

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q   <= req_type;
      exceed_q <= mag_now > {1'b0, speed_limit};
      lin_q    <= linear_in;
      ang_q    <= angular_in;
    end
  end

  assign lin_mag = lin_q[15] ? 16'(-lin_q) : lin_q;
  assign ang_mag = ang_q[15] ? 16'(-ang_q) : ang_q;
  assign clr     = least_clearance[16] ? 16'd0 : least_clearance[15:0];

  assign op_a = kind_q ? ang_mag : clr;
  assign op_b = kind_q ? {1'b0, speed_limit} : osg_pkg::MS_PER_S;
  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_q <= prod[osg_pkg::DIV_NUM_W-1:0];
    end
  end

  assign t_eff   = (safe_time_ms == 16'd0) ? 16'd1 : safe_time_ms;
  assign div_den = kind_q ? lin_mag : t_eff;

  osg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod_q),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign lim_sat = (|quo[osg_pkg::DIV_NUM_W-1:15]) ? osg_pkg::LIMIT_MAX : quo[14:0];
  assign q16     = {1'b0, quo[14:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= osg_pkg::LIMIT_MAX;
    end else if (cmd.finish && !kind_q) begin
      speed_limit <= lim_sat;
    end
  end

  assign load_out = cmd.finish && kind_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      was_limited <= exceed_q;
      if (exceed_q) begin
        // linear part scales to the limit itself
        linear_out  <= lin_q[15] ? -$signed({1'b0, speed_limit})
                                 : $signed({1'b0, speed_limit});
        angular_out <= ang_q[15] ? -$signed(q16) : $signed(q16);
      end else begin
        linear_out  <= lin_q;
        angular_out <= ang_q;
      end
    end
  end

  assign sts.kind_cmd_now = (req_type == osg_pkg::REQ_CMD);
  assign sts.last_now     = last_sample;
  assign sts.exceed_now   = mag_now > {1'b0, speed_limit};
  assign sts.kind_cmd     = kind_q;
  assign sts.div_done     = div_done;
  assign sts.out_free     = !out_valid || !out_stall;

  `OSG_ASSERT_IMPL(a_quo_fits, load_out && exceed_q,
                   quo[osg_pkg::DIV_NUM_W-1:15] == '0)
  `OSG_ASSERT_IMPL(a_limit_hold, !$past(rst) && !($past(cmd.finish) && !$past(kind_q)),
                   $stable(speed_limit))

endmodule

`default_nettype wire

/* src/obstacle_speed_governor_top.sv */
// ----------------------------------------------------------------------------
// Obstacle speed governor
// Time-to-collision speed limiter for laser range words and velocity commands.
// ----------------------------------------------------------------------------
// One word is taken at a time. A range sample that does not end a scan leaves
// the controller idle. A velocity command within the limit goes from accept
// straight to finish, which loads the output register. A scan-ending sample and
// a command that must be scaled go through accept, multiply, divider load, a
// wait while the shared divider runs (two quotient bits per cycle over a 30-bit
// dividend) until it reports done, then finish. A result waiting in the output
// register does not block the next word unless a new command result is ready
// to replace it. The limit starts at 32767 mm/s (unlimited) until the first scan
// ends. Configuration is to be written by the user only while idle, unchecked.
`default_nettype none

module obstacle_speed_governor_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [osg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          req_type,
  input  wire logic [15:0]                   range_mm,
  input  wire logic                          last_sample,
  input  wire logic signed [15:0]            linear_in,
  input  wire logic signed [15:0]            angular_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [15:0]                 linear_out,
  output logic signed [15:0]                 angular_out,
  output logic                               was_limited
);

  osg_pkg::osg_cmd_t cmd;
  osg_pkg::osg_sts_t sts;

  osg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  osg_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .range_mm    (range_mm),
    .last_sample (last_sample),
    .linear_in   (linear_in),
    .angular_in  (angular_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .linear_out  (linear_out),
    .angular_out (angular_out),
    .was_limited (was_limited),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

/* tb/sv/obstacle_speed_governor_top_tb.sv */
// ----------------------------------------------------------------------------
// Obstacle speed governor testbench
// Drives range and velocity words through the governor and checks every
// governed command against an in-bench model of the clearance tracking, the
// limit derivation and the proportional scaling. Includes directed corner
// words, configuration extremes, back-pressure and a long random run.
// ----------------------------------------------------------------------------

module obstacle_speed_governor_top_tb;

  import osg_pkg::*;

  typedef struct packed {
    logic signed [15:0] linear;
    logic signed [15:0] angular;
    logic               limited;
  } governed_cmd_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 req_type;
  logic [15:0]          range_mm;
  logic                 last_sample;
  logic signed [15:0]   linear_in;
  logic signed [15:0]   angular_in;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [15:0]   linear_out;
  logic signed [15:0]   angular_out;
  logic                 was_limited;

  // governor model state
  logic [15:0]        gov_safe_time;
  logic [15:0]        gov_radius;
  logic signed [16:0] gov_least_clr;
  logic               gov_scan_open;
  logic [14:0]        gov_limit;

  governed_cmd_t governed_cmd_q[$];
  governed_cmd_t next_cmd;
  int            mismatches = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  int            rx_hold_cycles = 0;

  obstacle_speed_governor_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .range_mm    (range_mm),
    .last_sample (last_sample),
    .linear_in   (linear_in),
    .angular_in  (angular_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .linear_out  (linear_out),
    .angular_out (angular_out),
    .was_limited (was_limited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  // magnitude times num over den, truncated toward zero
  function automatic int scale_toward_zero(int v, int unsigned num, int unsigned den);
    int unsigned av;
    int unsigned q;
    av = (v < 0) ? -v : v;
    q = av * num / den;
    return (v < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic void govern_word(logic kind, logic [15:0] rng, logic last,
                                      logic signed [15:0] lin, logic signed [15:0] ang);
    int            clr;
    int unsigned   t;
    int unsigned   c;
    int unsigned   lim;
    int unsigned   mag;
    int            l;
    int            a;
    governed_cmd_t res;
    if (kind == REQ_SCAN) begin
      clr = int'(rng) - int'(gov_radius);
      if (!gov_scan_open || clr < int'(gov_least_clr)) gov_least_clr = 17'(clr);
      gov_scan_open = 1'b1;
      if (last) begin
        t = (gov_safe_time == 16'd0) ? 1 : int'(gov_safe_time);
        c = (gov_least_clr > 0) ? int'(gov_least_clr) : 0;
        lim = c * 1000 / t;
        gov_limit = (lim > 32767) ? LIMIT_MAX : 15'(lim);
        gov_scan_open = 1'b0;
      end
    end else begin
      l = int'(lin);
      a = int'(ang);
      mag = (l < 0) ? -l : l;
      res.limited = 1'b0;
      if (mag > gov_limit) begin
        l = scale_toward_zero(l, gov_limit, mag);
        a = scale_toward_zero(a, gov_limit, mag);
        res.limited = 1'b1;
      end
      res.linear  = 16'(l);
      res.angular = 16'(a);
      governed_cmd_q.push_back(res);
    end
  endfunction

  // track register writes and accepted input words
  always @(posedge clk) begin
    if (rst) begin
      gov_safe_time = SAFE_TIME_RESET;
      gov_radius    = RADIUS_RESET;
      gov_least_clr = '0;
      gov_scan_open = 1'b0;
      gov_limit     = LIMIT_MAX;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAFE_TIME: gov_safe_time = cfg_data;
          REG_RADIUS:    gov_radius = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        govern_word(req_type, range_mm, last_sample, linear_in, angular_in);
    end
  end

  // compare each accepted result word with the oldest governed command
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (governed_cmd_q.size() == 0) begin
        $error("result word with no command pending");
        mismatches++;
      end else begin
        next_cmd = governed_cmd_q.pop_front();
        if (linear_out !== next_cmd.linear) begin
          $error("linear_out: expected %0d, actual %0d", next_cmd.linear, linear_out);
          mismatches++;
        end
        if (angular_out !== next_cmd.angular) begin
          $error("angular_out: expected %0d, actual %0d", next_cmd.angular, angular_out);
          mismatches++;
        end
        if (was_limited !== next_cmd.limited) begin
          $error("was_limited: expected %0d, actual %0d", next_cmd.limited, was_limited);
          mismatches++;
        end
      end
    end
  end

  // receiver: random hold-off per word, or a long hold when asked
  initial begin : rx_side
    int n;
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = rx_idle_on ? $urandom_range(0, 18) : 0;
      end
      out_stall <= (n > 0);
      if (n > 0) begin
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid && rx_hold_cycles == 0);
    end
  end

  task automatic send_word(logic kind, logic [15:0] rng, logic last,
                           logic signed [15:0] lin, logic signed [15:0] ang);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    range_mm    <= rng;
    last_sample <= last;
    linear_in   <= lin;
    angular_in  <= ang;
    do @(posedge clk); while (in_stall);
  endtask

  // unused fields of each word carry noise
  task automatic send_scan(logic [15:0] rng, logic last);
    send_word(REQ_SCAN, rng, last, 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
  endtask

  task automatic send_cmd(logic signed [15:0] lin, logic signed [15:0] ang);
    send_word(REQ_CMD, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), lin, ang);
  endtask

  task automatic send_noise();
    send_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
              1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
  endtask

  // hold the input, let results drain, then wait out a scan-ending division
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (governed_cmd_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_range();
    int r;
    case ($urandom_range(0, 3))
      0: r = $urandom_range(0, 65535);
      1: r = int'(gov_radius) + int'($urandom_range(0, 4000)) - 1000;
      2: r = $urandom_range(0, 1) ? 65535 : 0;
      default: r = $urandom_range(0, 2000);
    endcase
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return 16'(r);
  endfunction

  // linear speeds either anywhere or close to the current limit
  function automatic logic signed [15:0] pick_linear();
    int m;
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
    m = int'(gov_limit) + int'($urandom_range(0, 8)) - 4;
    if (m < 0) m = 0;
    if (m > 32768) m = 32768;
    return 16'($urandom_range(0, 1) ? -m : m);
  endfunction

  task automatic test_reset_limit();
    send_cmd(16'sd32767, 16'sd32767);
    send_cmd(-16'sd32767, -16'sd32768);
    send_cmd(-16'sd32768, 16'sd12345);
    send_cmd(16'sd0, 16'sd0);
    send_cmd(16'sd1, -16'sd1);
  endtask

  task automatic test_scan_cases();
    // single-sample scan: limit 200
    send_scan(16'd1200, 1'b1);
    send_cmd(16'sd200, 16'sd77);
    send_cmd(16'sd201, -16'sd32768);
    send_cmd(-16'sd400, 16'sd1000);
    // least clearance across a scan: limit 140
    send_scan(16'd3000, 1'b0);
    send_scan(16'd900, 1'b0);
    send_scan(16'd65535, 1'b1);
    send_cmd(-16'sd700, 16'sd350);
    // range inside the radius stops the robot
    send_scan(16'd50, 1'b1);
    send_cmd(16'sd0, 16'sd999);
    send_cmd(-16'sd32768, -16'sd32768);
    send_scan(16'd65535, 1'b1);
    send_cmd(16'sd32767, 16'sd32767);
  endtask

  task automatic test_config_extremes();
    wait_quiet();
    write_reg(REG_SAFE_TIME, 16'd0);
    write_reg(REG_RADIUS, 16'd0);
    send_scan(16'd40, 1'b1);
    send_cmd(-16'sd32768, 16'sd32767);
    send_cmd(16'sd30000, -16'sd5);
    wait_quiet();
    write_reg(REG_SAFE_TIME, 16'd65535);
    write_reg(REG_RADIUS, 16'd65535);
    send_scan(16'd65535, 1'b1);
    send_cmd(16'sd5, 16'sd5);
    wait_quiet();
    write_reg(REG_RADIUS, 16'd0);
    send_scan(16'd65535, 1'b1);
    send_cmd(16'sd1001, -16'sd1001);
    wait_quiet();
    write_reg(REG_SAFE_TIME, SAFE_TIME_RESET);
    write_reg(REG_RADIUS, RADIUS_RESET);
  endtask

  task automatic test_backpressure();
    wait_quiet();
    tx_idle_on = 1'b0;
    rx_hold_cycles = 300;
    send_scan(16'd2500, 1'b1);
    repeat (30) begin
      if ($urandom_range(0, 3) == 0) send_scan(pick_range(), 1'($urandom_range(0, 1)));
      else send_cmd(pick_linear(), 16'($urandom_range(0, 65535)));
    end
    // pause the sender until every result is out
    wait_quiet();
    tx_idle_on = 1'b1;
    rx_hold_cycles = 200;
    repeat (20) send_cmd(pick_linear(), 16'($urandom_range(0, 65535)));
    wait_quiet();
  endtask

  task automatic test_random_traffic();
    int  sent;
    int  n;
    int  k;
    bit  broken;
    for (int ph = 0; ph < 10; ph++) begin
      wait_quiet();
      case (ph)
        0: begin
          write_reg(REG_SAFE_TIME, 16'd1);
          write_reg(REG_RADIUS, 16'd0);
        end
        1: begin
          write_reg(REG_SAFE_TIME, 16'd65535);
          write_reg(REG_RADIUS, 16'd65535);
        end
        2: begin
          write_reg(REG_SAFE_TIME, 16'd0);
          write_reg(REG_RADIUS, 16'($urandom_range(0, 1000)));
        end
        default: begin
          case ($urandom_range(0, 2))
            0: write_reg(REG_SAFE_TIME, 16'($urandom_range(1, 50)));
            1: write_reg(REG_SAFE_TIME, 16'($urandom_range(1000, 10000)));
            default: write_reg(REG_SAFE_TIME, 16'($urandom_range(0, 65535)));
          endcase
          if ($urandom_range(0, 1)) write_reg(REG_RADIUS, 16'($urandom_range(0, 500)));
          else write_reg(REG_RADIUS, 16'($urandom_range(0, 65535)));
        end
      endcase
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 125) begin
        if ($urandom_range(0, 4) == 0) begin
          send_noise();
          sent++;
        end else begin
          // a scan then a few commands; now and then the end mark is dropped
          n = $urandom_range(1, 6);
          broken = ($urandom_range(0, 7) == 0);
          for (int i = 0; i < n; i++) send_scan(pick_range(), (i == n - 1) && !broken);
          k = $urandom_range(1, 4);
          for (int i = 0; i < k; i++) send_cmd(pick_linear(), 16'($urandom_range(0, 65535)));
          sent += n + k;
        end
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_SAFE_TIME;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    req_type    <= REQ_SCAN;
    range_mm    <= '0;
    last_sample <= 1'b0;
    linear_in   <= '0;
    angular_in  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_limit();
    test_scan_cases();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    wait_quiet();
    mismatches += governed_cmd_q.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/osg_pkg.sv
src/osg_div.sv
src/osg_ctrl.sv
src/osg_dpath.sv
src/obstacle_speed_governor_top.sv
tb/sv/obstacle_speed_governor_top_tb.sv
